/* rtl/core/otsem_pkg.sv */
`timescale 1ns / 1ps
// Owner-tracking semaphore: shared types and constants.
// No dependencies; imported by the top level.
package otsem_pkg;

  localparam int unsigned OTSEM_OWNER_SLOTS = 16;
  localparam int unsigned OTSEM_TID_BITS    = 16;

  // fixed beat field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TID_FLD_W = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned OUT_DAT_W = 16;

  localparam logic [COUNT_W-1:0] START_COUNT_RST = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_WAIT    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_BLOCK = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } state_e;

endpackage

/* rtl/core/otsem_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module otsem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/owner_tracking_semaphore.sv */
`timescale 1ns / 1ps
// Owner-tracking counting semaphore: top level with sequencer and owner scan.
// Depends on otsem_pkg and otsem_ram.
//
// Usage:
//   Requests arrive on the s_axis channel (operation in tuser, thread ID in
//   tdata); one response beat per request leaves on m_axis (status and count).
//   start_count and count_limit are set through the cfg write port while no
//   request is in flight.
// Sequencing / throughput:
//   Create, and any request while the semaphore is absent, go from accept
//   through S_EXEC to the output register load in S_RESP. Delete, wait and
//   release first scan the owner table in S_SCAN through one comparator fed by
//   the owner RAM read port, one slot per cycle, then go through S_EXEC/S_RESP.
//   s_axis_tready returns in the cycle after the output register load, and the
//   block takes one request at a time.
// Reset:
//   rst_ni clears the semaphore (absent, count 0, all slots free) and loads
//   the register defaults. The owner RAM is not cleared: only slots with a
//   set valid bit are ever compared.
// Backpressure:
//   The response sits in an output register. The next request is accepted
//   while it waits; that request's own response holds until m_axis_tready.
module owner_tracking_semaphore
  import otsem_pkg::*;
#(
  parameter int unsigned OWNER_SLOTS    = OTSEM_OWNER_SLOTS,
  parameter int unsigned THREAD_ID_BITS = OTSEM_TID_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TID_FLD_W-1:0] s_axis_tdata,   // [15:0] thread_id
  input  logic [OP_W-1:0]      s_axis_tuser,   // [1:0] operation
  // response channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DAT_W-1:0] m_axis_tdata,   // [1:0] status, [9:2] count_now, rest zero
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned TidW = (THREAD_ID_BITS < TID_FLD_W) ? THREAD_ID_BITS : TID_FLD_W;
  localparam int unsigned IdxW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(OWNER_SLOTS + 1);
  localparam logic [CntW-1:0] ScanEnd = CntW'(OWNER_SLOTS);

  state_e state_q, state_d;

  logic [COUNT_W-1:0]     start_q, limit_q;
  logic                   exists_q;
  logic [COUNT_W-1:0]     count_q;
  logic [OWNER_SLOTS-1:0] valid_q;

  op_e                    op_q;
  logic [TidW-1:0]        tid_q;
  status_e                status_q;

  logic [CntW-1:0]        cnt_q;
  logic                   pend_q;
  logic [IdxW-1:0]        cmp_idx_q;
  logic                   found_q, free_q;
  logic [IdxW-1:0]        found_idx_q, free_idx_q;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [COUNT_W-1:0]     out_count_q;

  logic                   in_beat, issue, out_load, wait_ok;
  logic                   ram_we, ram_re;
  logic [IdxW-1:0]        ram_waddr, ram_raddr;
  logic [TidW-1:0]        ram_rdata;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign issue    = (state_q == S_SCAN) && (cnt_q != ScanEnd);
  assign out_load = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);
  assign wait_ok  = exists_q && (op_q == OP_WAIT) && !found_q &&
                    (count_q < limit_q) && free_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (op_e'(s_axis_tuser) == OP_CREATE || !exists_q) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!issue && !pend_q) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = cnt_q[IdxW-1:0];
    ram_we        = 1'b0;
    ram_waddr     = free_idx_q;
    unique case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_SCAN: ram_re = issue;
      S_EXEC: begin
        if (op_q == OP_CREATE) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else begin
          ram_we = wait_ok;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  otsem_ram #(
    .WIDTH (TidW),
    .DEPTH (OWNER_SLOTS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tid_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= START_COUNT_RST;
      limit_q <= COUNT_LIMIT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_COUNT: start_q <= cfg_data_i;
          REG_COUNT_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // semaphore state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q <= 1'b0;
      count_q  <= '0;
      valid_q  <= '0;
    end else if (state_q == S_EXEC) begin
      case (op_q)
        OP_CREATE: begin
          exists_q   <= 1'b1;
          count_q    <= start_q;
          valid_q    <= '0;
          valid_q[0] <= 1'b1;
        end
        OP_DELETE: begin
          if (exists_q && found_q) begin
            exists_q <= 1'b0;
            count_q  <= '0;
            valid_q  <= '0;
          end
        end
        OP_WAIT: begin
          if (wait_ok) begin
            count_q             <= count_q + 1'b1;
            valid_q[free_idx_q] <= 1'b1;
          end
        end
        OP_RELEASE: begin
          if (exists_q && found_q) begin
            if (count_q != '0) begin
              count_q <= count_q - 1'b1;
            end
            valid_q[found_idx_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (in_beat) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (state_q == S_SCAN) begin
      pend_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // read data of the slot issued last cycle is here now
      if (pend_q) begin
        if (valid_q[cmp_idx_q] && ram_rdata == tid_q && !found_q) begin
          found_q <= 1'b1;
        end
        if (!valid_q[cmp_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= op_e'(s_axis_tuser);
      tid_q <= s_axis_tdata[TidW-1:0];
    end
    if (state_q == S_SCAN) begin
      cmp_idx_q <= cnt_q[IdxW-1:0];
      if (pend_q) begin
        if (valid_q[cmp_idx_q] && ram_rdata == tid_q && !found_q) begin
          found_idx_q <= cmp_idx_q;
        end
        if (!valid_q[cmp_idx_q] && !free_q) begin
          free_idx_q <= cmp_idx_q;
        end
      end
    end
    if (state_q == S_EXEC) begin
      if (op_q == OP_CREATE) begin
        status_q <= ST_OK;
      end else if (!exists_q) begin
        status_q <= ST_ERR;
      end else begin
        case (op_q)
          OP_WAIT: begin
            if (found_q) begin
              status_q <= ST_ERR;
            end else if (count_q >= limit_q) begin
              status_q <= ST_BLOCK;
            end else if (!free_q) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_OK;
            end
          end
          OP_DELETE, OP_RELEASE: status_q <= found_q ? ST_OK : ST_ERR;
          default: status_q <= ST_OK;
        endcase
      end
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DAT_W - STATUS_W - COUNT_W){1'b0}}, out_count_q, out_status_q};

  // checks
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exists_q |-> count_q == '0)
    else $error("count nonzero while semaphore absent");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q != S_IDLE)
    else $error("sequencer idle right after accepting a request");

  a_create_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == OP_CREATE) |=> exists_q && valid_q[0])
    else $error("create did not record the requester in slot 0");

  a_resp_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && state_q == S_IDLE)
    else $error("response not presented after load");

endmodule

/* tb/owner_tracking_semaphore_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for owner_tracking_semaphore: drives request beats with
// random gaps, predicts each response in-bench and checks it. Needs otsem_pkg.
module owner_tracking_semaphore_tb;
  import otsem_pkg::*;

  localparam int unsigned SLOTS    = OTSEM_OWNER_SLOTS;
  localparam int unsigned POOL_N   = 20;
  localparam int unsigned DRAIN_MAX = 5000;
  localparam int unsigned SETTLE   = 25;   // longer than a full owner-table scan

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   count;
  } sem_resp_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TID_FLD_W-1:0] s_axis_tdata;   // [15:0] thread_id
  logic [OP_W-1:0]      s_axis_tuser;   // [1:0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_DAT_W-1:0] m_axis_tdata;   // [1:0] status, [9:2] count_now, rest zero
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  owner_tracking_semaphore uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the semaphore
  logic                 sem_live;
  logic [COUNT_W-1:0]   sem_count;
  logic [TID_FLD_W-1:0] owner_tid  [SLOTS];
  logic                 owner_used [SLOTS];
  logic [COUNT_W-1:0]   start_reg;
  logic [COUNT_W-1:0]   limit_reg;

  sem_resp_t pending_resp [$];

  bit tx_gaps;
  bit rx_gaps;
  int rx_hold_len;
  int mismatches;
  int requests_sent;
  int responses_seen;
  int reg_writes;
  int status_tally [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d responses still outstanding", pending_resp.size());
    $display("FAIL owner_tracking_semaphore");
    $finish;
  end

  // Next response for one request; updates the shadow state.
  function automatic sem_resp_t apply_request(op_e op, logic [TID_FLD_W-1:0] tid);
    sem_resp_t r;
    int        hit;
    int        free_slot;
    int        i;
    r.status  = ST_OK;
    hit       = -1;
    free_slot = -1;
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (owner_used[i] && owner_tid[i] == tid) hit = i;
      if (!owner_used[i]) free_slot = i;
    end
    if (op == OP_CREATE) begin
      sem_live  = 1'b1;
      sem_count = start_reg;
      for (i = 0; i < SLOTS; i++) owner_used[i] = 1'b0;
      owner_tid[0]  = tid;
      owner_used[0] = 1'b1;
    end else if (!sem_live) begin
      r.status = ST_ERR;
    end else if (op == OP_DELETE) begin
      if (hit < 0) begin
        r.status = ST_ERR;
      end else begin
        sem_live  = 1'b0;
        sem_count = '0;
        for (i = 0; i < SLOTS; i++) owner_used[i] = 1'b0;
      end
    end else if (op == OP_WAIT) begin
      if (hit >= 0) r.status = ST_ERR;
      else if (sem_count >= limit_reg) r.status = ST_BLOCK;   // limit checked before free slots
      else if (free_slot < 0) r.status = ST_FULL;
      else begin
        sem_count             = sem_count + 1'b1;
        owner_tid[free_slot]  = tid;
        owner_used[free_slot] = 1'b1;
      end
    end else begin
      if (hit < 0) begin
        r.status = ST_ERR;
      end else begin
        if (sem_count != 0) sem_count = sem_count - 1'b1;
        owner_used[hit] = 1'b0;   // slot freed even at count zero
      end
    end
    r.count = sem_count;
    return r;
  endfunction

  task automatic report_mismatch(string fld, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: response %0d %s mismatch: expected %h, got %h",
               $realtime, responses_seen, fld, want, got);
  endtask

  // One request beat. tvalid is only lowered when a gap follows.
  task automatic send_req(op_e op, logic [TID_FLD_W-1:0] tid);
    int        gap;
    sem_resp_t r;
    gap = tx_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tid;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_request(op, tid);
    pending_resp.push_back(r);
    status_tally[r.status]++;
    requests_sent++;
  endtask

  // Sender pause: all responses back, then let the block settle.
  task automatic wait_drained();
    int n;
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (pending_resp.size() != 0 && n < DRAIN_MAX) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_resp.size() != 0) begin
      mismatches++;
      $display("%0t: %0d responses never arrived", $realtime, pending_resp.size());
      pending_resp.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [COUNT_W-1:0] start_val, logic [COUNT_W-1:0] limit_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_START_COUNT;
    cfg_data_i  <= start_val;
    @(posedge clk_i);
    cfg_index_i <= REG_COUNT_LIMIT;
    cfg_data_i  <= limit_val;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    start_reg  = start_val;
    limit_reg  = limit_val;
    reg_writes += 2;
  endtask

  // response side: per-beat stall, or one long hold when asked
  initial begin : rx_side
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 14) : 0;
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : resp_check
    sem_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      responses_seen++;
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected beat", 16'h0, m_axis_tdata);
      end else begin
        want = pending_resp.pop_front();
        if (m_axis_tdata[STATUS_W-1:0] !== want.status)
          report_mismatch("status", 16'(want.status), 16'(m_axis_tdata[STATUS_W-1:0]));
        if (m_axis_tdata[STATUS_W +: COUNT_W] !== want.count)
          report_mismatch("count_now", 16'(want.count),
                          16'(m_axis_tdata[STATUS_W +: COUNT_W]));
        if (m_axis_tdata[OUT_DAT_W-1:STATUS_W+COUNT_W] !== '0)
          report_mismatch("padding", 16'h0,
                          16'(m_axis_tdata[OUT_DAT_W-1:STATUS_W+COUNT_W]));
      end
    end
  end

  // defaults after reset: start 0, limit 1
  task automatic test_basic_ops();
    send_req(OP_WAIT,    16'h0001);   // absent
    send_req(OP_RELEASE, 16'h0001);
    send_req(OP_DELETE,  16'hFFFF);
    send_req(OP_CREATE,  16'h0000);
    send_req(OP_WAIT,    16'h0000);   // already owner
    send_req(OP_WAIT,    16'hFFFF);
    send_req(OP_WAIT,    16'h5A5A);   // at limit
    send_req(OP_RELEASE, 16'h0000);
    send_req(OP_RELEASE, 16'h0000);   // no longer owner
    send_req(OP_DELETE,  16'hA5A5);
    send_req(OP_RELEASE, 16'hFFFF);   // count already zero, slot still freed
    send_req(OP_WAIT,    16'hFFFF);
    send_req(OP_DELETE,  16'hFFFF);
    send_req(OP_CREATE,  16'h8001);
    send_req(OP_WAIT,    16'h7FFE);
    send_req(OP_CREATE,  16'h1234);   // re-create drops all owners
    send_req(OP_RELEASE, 16'h7FFE);
    send_req(OP_DELETE,  16'h1234);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    program_regs(8'd255, 8'd0);       // limit zero: every wait blocks
    send_req(OP_CREATE,  16'h00FF);
    send_req(OP_WAIT,    16'hFF00);
    send_req(OP_RELEASE, 16'h00FF);
    send_req(OP_CREATE,  16'h00FF);
    send_req(OP_WAIT,    16'hFF00);
    wait_drained();
    program_regs(8'd254, 8'd255);
    send_req(OP_CREATE,  16'h0F0F);
    send_req(OP_WAIT,    16'hF0F0);
    send_req(OP_WAIT,    16'h3C3C);
    send_req(OP_RELEASE, 16'hF0F0);
    send_req(OP_DELETE,  16'h0F0F);
    wait_drained();
  endtask

  task automatic test_table_full();
    int i;
    program_regs(8'd0, 8'd255);
    send_req(OP_CREATE, 16'hC000);
    for (i = 1; i < SLOTS; i++) send_req(OP_WAIT, 16'hC000 + i[15:0]);
    send_req(OP_WAIT,    16'hBEEF);   // all slots taken
    send_req(OP_RELEASE, 16'hC003);
    send_req(OP_WAIT,    16'hBEEF);
    send_req(OP_WAIT,    16'h0BAD);
    send_req(OP_DELETE,  16'hC007);
    wait_drained();
  endtask

  // receiver stalls long while requests keep coming back to back
  task automatic test_backpressure();
    int i;
    tx_gaps     = 1'b0;
    rx_hold_len = 300;
    send_req(OP_CREATE, 16'h0003);
    for (i = 0; i < 11; i++)
      send_req($urandom_range(0, 1) ? OP_WAIT : OP_RELEASE, 16'($urandom_range(0, 7)));
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  task automatic random_phase(int n_req);
    logic [TID_FLD_W-1:0] pool [POOL_N];
    logic [TID_FLD_W-1:0] tid;
    op_e                  op;
    int                   k;
    int                   pick;
    int                   wait_pct;
    pool[0] = '0;
    pool[1] = '1;
    for (k = 2; k < POOL_N; k++) pool[k] = 16'($urandom_range(0, 65535));
    wait_pct = 47;
    for (k = 0; k < n_req; k++) begin
      if (k % 40 == 0) begin
        tx_gaps  = $urandom_range(0, 3) != 0;
        rx_gaps  = $urandom_range(0, 3) != 0;
        wait_pct = $urandom_range(0, 1) ? 47 : 75;   // fill bias pushes toward a full table
      end
      tid  = pool[$urandom_range(0, POOL_N - 1)];
      pick = $urandom_range(0, 99);
      if (!sem_live && pick < 80) op = OP_CREATE;
      else if (pick < 3) op = OP_CREATE;
      else if (pick < 6) op = OP_DELETE;
      else if (pick < 6 + wait_pct) op = OP_WAIT;
      else if (pick < 95) op = OP_RELEASE;
      else begin
        op  = op_e'($urandom_range(0, 3));
        tid = 16'($urandom_range(0, 65535));
      end
      send_req(op, tid);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    program_regs(8'd0, 8'd1);
    random_phase(240);
    program_regs(8'd0, 8'd255);
    random_phase(240);
    program_regs(8'd255, 8'd255);
    random_phase(240);
    program_regs(8'd3, 8'd0);
    random_phase(200);
    program_regs(8'd128, 8'd140);
    random_phase(240);
    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
    random_phase(240);
  endtask

  initial begin : main
    int i;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CREATE;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_START_COUNT;
    cfg_data_i    <= '0;
    sem_live  = 1'b0;
    sem_count = '0;
    for (i = 0; i < SLOTS; i++) begin
      owner_tid[i]  = '0;
      owner_used[i] = 1'b0;
    end
    start_reg   = START_COUNT_RST;
    limit_reg   = COUNT_LIMIT_RST;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    rx_hold_len = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_ops();
    test_register_extremes();
    test_table_full();
    test_backpressure();
    test_random_phases();
    wait_drained();

    $display("run: %0d requests, %0d responses, %0d register writes, %0d mismatches",
             requests_sent, responses_seen, reg_writes, mismatches);
    $display("status mix: ok %0d, error %0d, would-block %0d, owners full %0d",
             status_tally[ST_OK], status_tally[ST_ERR], status_tally[ST_BLOCK],
             status_tally[ST_FULL]);
    if (mismatches == 0) begin
      $display("PASS owner_tracking_semaphore");
    end else begin
      $display("FAIL owner_tracking_semaphore");
    end
    $finish;
  end

endmodule

/* owner_tracking_semaphore.f */
rtl/core/otsem_pkg.sv
rtl/core/otsem_ram.sv
rtl/core/owner_tracking_semaphore.sv
tb/owner_tracking_semaphore_tb.sv
